// ----- rtl/stc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stc_pkg: shared types and constants of the corner response block
// Widths of the gradient, column-sum, window-sum and product paths, the
// register map and the structs that pass between the front, queue and back.
// ----------------------------------------------------------------------------
package stc_pkg;

  // image and window limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MAX_RADIUS = 7;
  localparam int LANES      = 2 * MAX_RADIUS + 1;
  localparam int SLOT_W     = $clog2(LANES);

  // field widths
  localparam int GRAD_W   = 16;
  localparam int LANE_W   = 2 * GRAD_W;
  localparam int ROW_W    = 10;
  localparam int COL_W    = 10;
  localparam int DIM_W    = 11;
  localparam int RAD_W    = 3;
  localparam int DTHR_W   = 24;
  localparam int RTHR_W   = 15;
  localparam int RESP_W   = 15;
  localparam int LIN_W    = 21;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // arithmetic widths
  localparam int CS_W      = 34;             // column sum of squares
  localparam int CSXY_W    = 35;             // column sum of cross terms, signed
  localparam int WS_W      = 38;             // window sum of squares
  localparam int TR_W      = 39;             // trace, magnitude, signed cross sum
  localparam int MUL_LO_W  = 20;             // low half of a multiplier operand
  localparam int PROD_W    = TR_W + MUL_LO_W;
  localparam int PP_W      = 2 * TR_W;       // full product
  localparam int FRAC_W    = 16;             // ratio fraction bits
  localparam int NUM_W     = PP_W + FRAC_W;
  localparam int DTHR_SH   = 32;             // det threshold scaling
  localparam int RESP_MAX  = 16384;

  // reset values of the registers
  localparam int RST_WIDTH     = 1024;
  localparam int RST_HEIGHT    = 1024;
  localparam int RST_RADIUS    = 3;
  localparam int RST_DET_THR   = 1000;
  localparam int RST_RATIO_THR = 13107;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH,
    REG_HEIGHT,
    REG_RADIUS,
    REG_DET_THR,
    REG_RATIO_THR
  } reg_idx_e;

  // clamped configuration as seen by the datapath
  typedef struct packed {
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic [RAD_W-1:0]  radius;
    logic [DTHR_W-1:0] det_thr;
    logic [RTHR_W-1:0] ratio_thr;
  } cfg_t;

  // one classified pixel: its column sums and the window center it reports
  typedef struct packed {
    logic [CS_W-1:0]   xx;
    logic [CS_W-1:0]   yy;
    logic [CSXY_W-1:0] xy;
    logic [ROW_W-1:0]  center_row;
    logic [COL_W-1:0]  center_col;
    logic              in_region;
  } col_item_t;

endpackage

// ----- rtl/stc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stc_front: pixel intake, line store and column sums
// Accepts one gradient beat, updates the raster position, writes the line
// store, sums the column of squares and cross terms over 2r+1 lines and locates the window
// center with a serial divider. Clears the line store after reset.
// ----------------------------------------------------------------------------
module stc_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  stc_pkg::cfg_t                     cfg_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [stc_pkg::GRAD_W-1:0] grad_x_i,
  input  logic signed [stc_pkg::GRAD_W-1:0] grad_y_i,
  output logic                              push_o,
  output stc_pkg::col_item_t                push_data_o,
  input  logic                              full_i
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_SUM,
    ST_WAIT
  } state_e;

  localparam int RowBits = stc_pkg::LANES * stc_pkg::LANE_W;

  state_e                              state_q;
  logic [stc_pkg::COL_W-1:0]           clr_addr_q;
  logic [stc_pkg::ROW_W-1:0]           pix_row_q;
  logic [stc_pkg::COL_W-1:0]           pix_col_q;
  logic [stc_pkg::SLOT_W-1:0]          slot_q;
  logic [stc_pkg::COL_W-1:0]           cur_col_q;
  logic [stc_pkg::SLOT_W-1:0]          cur_slot_q;
  logic [stc_pkg::GRAD_W-1:0]          gx_q;
  logic [stc_pkg::GRAD_W-1:0]          gy_q;
  logic [RowBits-1:0]                  rd_data_q;
  logic [RowBits-1:0]                  lanes_q;
  logic [stc_pkg::SLOT_W-1:0]          lane_q;
  logic [stc_pkg::SLOT_W-1:0]          k_q;
  logic [stc_pkg::CS_W-1:0]            sxx_q;
  logic [stc_pkg::CS_W-1:0]            syy_q;
  logic [stc_pkg::CSXY_W-1:0]          sxy_q;
  logic [stc_pkg::LIN_W-1:0]           dvd_q;
  logic [stc_pkg::LIN_W-1:0]           quo_q;
  logic [stc_pkg::DIM_W-1:0]           rem_q;
  logic [4:0]                          dcnt_q;
  logic                                div_busy_q;
  logic                                nocenter_q;

  logic [RowBits-1:0]                  line_mem [stc_pkg::MAX_WIDTH];

  logic                                accept;
  logic                                mem_we;
  logic [stc_pkg::COL_W-1:0]           mem_addr;
  logic [RowBits-1:0]                  mem_wdata;
  logic [RowBits-1:0]                  row_w;
  logic [stc_pkg::LIN_W-1:0]           lin;
  logic [stc_pkg::LIN_W-1:0]           dly;
  logic [stc_pkg::DIM_W:0]             trial;
  logic                                trial_ge;
  logic signed [stc_pkg::GRAD_W-1:0]   sel_x;
  logic signed [stc_pkg::GRAD_W-1:0]   sel_y;
  logic signed [stc_pkg::LANE_W-1:0]   pxx;
  logic signed [stc_pkg::LANE_W-1:0]   pyy;
  logic signed [stc_pkg::LANE_W-1:0]   pxy;
  logic                                region;
  logic [stc_pkg::SLOT_W-1:0]          last_k;

  // handshake
  assign accept     = (state_q == ST_IDLE) && in_valid_i;
  assign in_stall_o = (state_q != ST_IDLE);
  assign push_o     = (state_q == ST_WAIT) && !div_busy_q && !full_i;
  assign last_k     = {cfg_i.radius, 1'b0};

  // raster index of this pixel and the delay back to its window center
  assign lin = stc_pkg::LIN_W'(pix_row_q) * stc_pkg::LIN_W'(cfg_i.width)
             + stc_pkg::LIN_W'(pix_col_q);
  assign dly = stc_pkg::LIN_W'(cfg_i.radius) * stc_pkg::LIN_W'(cfg_i.width)
             + stc_pkg::LIN_W'(cfg_i.radius);

  // one restoring divide step by the image width
  assign trial    = {rem_q, dvd_q[stc_pkg::LIN_W-1]};
  assign trial_ge = trial >= {1'b0, cfg_i.width};

  // merge the new pixel into the line store row
  always_comb begin
    row_w = rd_data_q;
    row_w[cur_slot_q*stc_pkg::LANE_W +: stc_pkg::LANE_W] = {gy_q, gx_q};
  end

  assign mem_we    = (state_q == ST_CLEAR) || (state_q == ST_LOAD);
  assign mem_addr  = (state_q == ST_CLEAR) ? clr_addr_q : cur_col_q;
  assign mem_wdata = (state_q == ST_CLEAR) ? '0 : row_w;

  // line store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_mem[mem_addr] <= mem_wdata;
    end
    if (accept) begin
      rd_data_q <= line_mem[pix_col_q];
    end
  end

  // products of the selected line
  assign sel_x = $signed(lanes_q[lane_q*stc_pkg::LANE_W +: stc_pkg::GRAD_W]);
  assign sel_y = $signed(lanes_q[lane_q*stc_pkg::LANE_W + stc_pkg::GRAD_W +: stc_pkg::GRAD_W]);
  assign pxx   = sel_x * sel_x;
  assign pyy   = sel_y * sel_y;
  assign pxy   = sel_x * sel_y;

  // window around the center lies inside the image
  assign region = !nocenter_q
    && (quo_q >= stc_pkg::LIN_W'(cfg_i.radius))
    && ((stc_pkg::LIN_W+1)'(quo_q) + (stc_pkg::LIN_W+1)'(cfg_i.radius)
        < (stc_pkg::LIN_W+1)'(cfg_i.height))
    && (rem_q >= stc_pkg::DIM_W'(cfg_i.radius))
    && ((stc_pkg::DIM_W+1)'(rem_q) + (stc_pkg::DIM_W+1)'(cfg_i.radius)
        < (stc_pkg::DIM_W+1)'(cfg_i.width));

  always_comb begin
    push_data_o            = '0;
    push_data_o.xx         = sxx_q;
    push_data_o.yy         = syy_q;
    push_data_o.xy         = sxy_q;
    push_data_o.center_row = quo_q[stc_pkg::ROW_W-1:0];
    push_data_o.center_col = rem_q[stc_pkg::COL_W-1:0];
    push_data_o.in_region  = region;
  end

  // sequencer, position, column sum and divider
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_addr_q <= '0;
      pix_row_q  <= '0;
      pix_col_q  <= '0;
      slot_q     <= '0;
      cur_col_q  <= '0;
      cur_slot_q <= '0;
      gx_q       <= '0;
      gy_q       <= '0;
      lanes_q    <= '0;
      lane_q     <= '0;
      k_q        <= '0;
      sxx_q      <= '0;
      syy_q      <= '0;
      sxy_q      <= '0;
      dvd_q      <= '0;
      quo_q      <= '0;
      rem_q      <= '0;
      dcnt_q     <= '0;
      div_busy_q <= 1'b0;
      nocenter_q <= 1'b1;
    end else begin
      // advance the divider one quotient bit
      if (div_busy_q) begin
        dvd_q  <= {dvd_q[stc_pkg::LIN_W-2:0], 1'b0};
        quo_q  <= {quo_q[stc_pkg::LIN_W-2:0], trial_ge};
        rem_q  <= trial_ge ? stc_pkg::DIM_W'(trial - {1'b0, cfg_i.width})
                           : stc_pkg::DIM_W'(trial);
        dcnt_q <= dcnt_q + 5'd1;
        if (dcnt_q == 5'(stc_pkg::LIN_W - 1)) begin
          div_busy_q <= 1'b0;
        end
      end

      case (state_q)
        ST_CLEAR: begin
          clr_addr_q <= clr_addr_q + 1'b1;
          if (clr_addr_q == stc_pkg::COL_W'(stc_pkg::MAX_WIDTH - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid_i) begin
            gx_q       <= grad_x_i;
            gy_q       <= grad_y_i;
            cur_col_q  <= pix_col_q;
            cur_slot_q <= slot_q;
            // advance the raster position
            if (stc_pkg::DIM_W'(pix_col_q) + stc_pkg::DIM_W'(1) >= cfg_i.width) begin
              pix_col_q <= '0;
              if (stc_pkg::DIM_W'(pix_row_q) + stc_pkg::DIM_W'(1) >= cfg_i.height) begin
                pix_row_q <= '0;
                slot_q    <= '0;
              end else begin
                pix_row_q <= pix_row_q + 1'b1;
                slot_q    <= (slot_q == stc_pkg::SLOT_W'(stc_pkg::LANES - 1)) ? '0
                                                                         : slot_q + 1'b1;
              end
            end else begin
              pix_col_q <= pix_col_q + 1'b1;
              if (stc_pkg::DIM_W'(pix_row_q) >= cfg_i.height) begin
                pix_row_q <= '0;
                slot_q    <= '0;
              end
            end
            // start the center divide
            quo_q  <= '0;
            rem_q  <= '0;
            dcnt_q <= '0;
            if (lin < dly) begin
              nocenter_q <= 1'b1;
              div_busy_q <= 1'b0;
              dvd_q      <= '0;
            end else begin
              nocenter_q <= 1'b0;
              div_busy_q <= 1'b1;
              dvd_q      <= lin - dly;
            end
            state_q <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          lanes_q <= row_w;
          lane_q  <= cur_slot_q;
          k_q     <= '0;
          sxx_q   <= '0;
          syy_q   <= '0;
          sxy_q   <= '0;
          state_q <= ST_SUM;
        end
        ST_SUM: begin
          sxx_q  <= sxx_q + stc_pkg::CS_W'($unsigned(pxx));
          syy_q  <= syy_q + stc_pkg::CS_W'($unsigned(pyy));
          sxy_q  <= sxy_q + stc_pkg::CSXY_W'(pxy);
          lane_q <= (lane_q == '0) ? stc_pkg::SLOT_W'(stc_pkg::LANES - 1) : lane_q - 1'b1;
          k_q    <= k_q + 1'b1;
          if (k_q == last_k) begin
            state_q <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (!div_busy_q && !full_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/stc_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stc_queue: short queue between front and back
// Holds classified pixels so that intake and response math stall apart.
// ----------------------------------------------------------------------------
module stc_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  stc_pkg::col_item_t push_data_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output stc_pkg::col_item_t pop_data_o
);

  stc_pkg::col_item_t          entry_q [stc_pkg::QUEUE_DEPTH];
  logic [stc_pkg::QPTR_W-1:0]  wr_ptr_q;
  logic [stc_pkg::QPTR_W-1:0]  rd_ptr_q;
  logic [stc_pkg::QPTR_W:0]    count_q;

  assign full_o     = (count_q == (stc_pkg::QPTR_W+1)'(stc_pkg::QUEUE_DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = entry_q[rd_ptr_q];

  // store beats
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  // advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/stc_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stc_back: window sums, tensor products and corner decision
// Keeps the last 15 column sums, adds 2r+1 of them, forms det and trace
// squared on one shared split multiplier, divides det by trace squared one
// bit a step and holds the result in an output register.
// ----------------------------------------------------------------------------
module stc_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  stc_pkg::cfg_t              cfg_i,
  input  logic                       pop_valid_i,
  input  stc_pkg::col_item_t         pop_data_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [stc_pkg::ROW_W-1:0]  center_row_o,
  output logic [stc_pkg::COL_W-1:0]  center_col_o,
  output logic                       in_region_o,
  output logic                       is_corner_o,
  output logic [stc_pkg::RESP_W-1:0] response_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WSUM,
    ST_PREP,
    ST_MUL,
    ST_DET,
    ST_DIV,
    ST_FIN
  } state_e;

  state_e                         state_q;
  logic [stc_pkg::CS_W-1:0]       tap_xx_q [stc_pkg::LANES];
  logic [stc_pkg::CS_W-1:0]       tap_yy_q [stc_pkg::LANES];
  logic [stc_pkg::CSXY_W-1:0]     tap_xy_q [stc_pkg::LANES];
  logic [stc_pkg::SLOT_W-1:0]     j_q;
  logic [stc_pkg::WS_W-1:0]       wxx_q;
  logic [stc_pkg::WS_W-1:0]       wyy_q;
  logic [stc_pkg::TR_W-1:0]       wxy_q;
  logic [stc_pkg::TR_W-1:0]       tr_q;
  logic [stc_pkg::TR_W-1:0]       mag_q;
  logic [2:0]                     m_q;
  logic [stc_pkg::PP_W-1:0]       pd_q;
  logic [stc_pkg::PP_W-1:0]       pc_q;
  logic [stc_pkg::PP_W-1:0]       tr2_q;
  logic [stc_pkg::NUM_W-1:0]      rem_q;
  logic [stc_pkg::NUM_W-1:0]      dsr_q;
  logic [stc_pkg::RESP_W-1:0]     quo_q;
  logic [stc_pkg::SLOT_W-1:0]     b_q;
  logic                           detok_q;
  logic                           region_q;
  logic [stc_pkg::ROW_W-1:0]      crow_q;
  logic [stc_pkg::COL_W-1:0]      ccol_q;
  logic                           out_valid_q;
  logic [stc_pkg::ROW_W-1:0]      out_row_q;
  logic [stc_pkg::COL_W-1:0]      out_col_q;
  logic                           out_region_q;
  logic                           out_corner_q;
  logic [stc_pkg::RESP_W-1:0]     out_resp_q;

  logic [stc_pkg::SLOT_W-1:0]     last_j;
  logic [stc_pkg::TR_W-1:0]       op_a;
  logic [stc_pkg::TR_W-1:0]       op_b;
  logic [stc_pkg::MUL_LO_W-1:0]   op_bh;
  logic [stc_pkg::PROD_W-1:0]     prod;
  logic [stc_pkg::PP_W-1:0]       term;
  logic [stc_pkg::PP_W-1:0]       det;
  logic                           rem_ge;
  logic                           corner;
  logic                           out_free;

  assign last_j   = {cfg_i.radius, 1'b0};
  assign pop_o    = (state_q == ST_IDLE) && pop_valid_i;
  assign out_free = !out_valid_q || !out_stall_i;

  // shared multiplier: one operand split into a low and a high half, taken in turn
  always_comb begin
    case (m_q[2:1])
      2'd0: begin
        op_a = stc_pkg::TR_W'(wxx_q);
        op_b = stc_pkg::TR_W'(wyy_q);
      end
      2'd1: begin
        op_a = mag_q;
        op_b = mag_q;
      end
      default: begin
        op_a = tr_q;
        op_b = tr_q;
      end
    endcase
  end

  assign op_bh = m_q[0] ? stc_pkg::MUL_LO_W'(op_b[stc_pkg::TR_W-1:stc_pkg::MUL_LO_W])
                        : op_b[stc_pkg::MUL_LO_W-1:0];
  assign prod  = stc_pkg::PROD_W'(op_a) * stc_pkg::PROD_W'(op_bh);
  assign term  = m_q[0] ? (stc_pkg::PP_W'(prod) << stc_pkg::MUL_LO_W) : stc_pkg::PP_W'(prod);

  // determinant, never below zero
  assign det    = (pc_q > pd_q) ? '0 : pd_q - pc_q;
  assign rem_ge = rem_q >= dsr_q;

  // ratio test from quotient and remainder
  assign corner = region_q && detok_q
               && ((quo_q > cfg_i.ratio_thr) || ((quo_q == cfg_i.ratio_thr) && (rem_q != '0)));

  assign out_valid_o  = out_valid_q;
  assign center_row_o = out_row_q;
  assign center_col_o = out_col_q;
  assign in_region_o  = out_region_q;
  assign is_corner_o  = out_corner_q;
  assign response_o   = out_resp_q;

  // column sum delay line
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      tap_xx_q[0] <= pop_data_i.xx;
      tap_yy_q[0] <= pop_data_i.yy;
      tap_xy_q[0] <= pop_data_i.xy;
      for (int i = 1; i < stc_pkg::LANES; i++) begin
        tap_xx_q[i] <= tap_xx_q[i-1];
        tap_yy_q[i] <= tap_yy_q[i-1];
        tap_xy_q[i] <= tap_xy_q[i-1];
      end
    end
  end

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      j_q          <= '0;
      wxx_q        <= '0;
      wyy_q        <= '0;
      wxy_q        <= '0;
      tr_q         <= '0;
      mag_q        <= '0;
      m_q          <= '0;
      pd_q         <= '0;
      pc_q         <= '0;
      tr2_q        <= '0;
      rem_q        <= '0;
      dsr_q        <= '0;
      quo_q        <= '0;
      b_q          <= '0;
      detok_q      <= 1'b0;
      region_q     <= 1'b0;
      crow_q       <= '0;
      ccol_q       <= '0;
      out_valid_q  <= 1'b0;
      out_row_q    <= '0;
      out_col_q    <= '0;
      out_region_q <= 1'b0;
      out_corner_q <= 1'b0;
      out_resp_q   <= '0;
    end else begin
      // drop a beat that was taken
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (pop_valid_i) begin
            crow_q   <= pop_data_i.center_row;
            ccol_q   <= pop_data_i.center_col;
            region_q <= pop_data_i.in_region;
            detok_q  <= 1'b0;
            quo_q    <= '0;
            rem_q    <= '0;
            j_q      <= '0;
            wxx_q    <= '0;
            wyy_q    <= '0;
            wxy_q    <= '0;
            state_q  <= pop_data_i.in_region ? ST_WSUM : ST_FIN;
          end
        end
        ST_WSUM: begin
          wxx_q <= wxx_q + stc_pkg::WS_W'(tap_xx_q[j_q]);
          wyy_q <= wyy_q + stc_pkg::WS_W'(tap_yy_q[j_q]);
          wxy_q <= wxy_q + stc_pkg::TR_W'($signed(tap_xy_q[j_q]));
          j_q   <= j_q + 1'b1;
          if (j_q == last_j) begin
            state_q <= ST_PREP;
          end
        end
        ST_PREP: begin
          tr_q    <= stc_pkg::TR_W'(wxx_q) + stc_pkg::TR_W'(wyy_q);
          mag_q   <= wxy_q[stc_pkg::TR_W-1] ? (~wxy_q + 1'b1) : wxy_q;
          m_q     <= '0;
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          case (m_q[2:1])
            2'd0:    pd_q  <= m_q[0] ? pd_q + term : term;
            2'd1:    pc_q  <= m_q[0] ? pc_q + term : term;
            default: tr2_q <= m_q[0] ? tr2_q + term : term;
          endcase
          m_q <= m_q + 1'b1;
          if (m_q == 3'd5) begin
            state_q <= ST_DET;
          end
        end
        ST_DET: begin
          detok_q <= det > stc_pkg::PP_W'({cfg_i.det_thr, stc_pkg::DTHR_SH'(0)});
          rem_q   <= {det, stc_pkg::FRAC_W'(0)};
          dsr_q   <= stc_pkg::NUM_W'(tr2_q) << (stc_pkg::RESP_W - 1);
          quo_q   <= '0;
          b_q     <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (rem_ge) begin
            rem_q <= rem_q - dsr_q;
          end
          quo_q <= {quo_q[stc_pkg::RESP_W-2:0], rem_ge};
          dsr_q <= dsr_q >> 1;
          b_q   <= b_q + 1'b1;
          if (b_q == stc_pkg::SLOT_W'(stc_pkg::RESP_W - 1)) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_row_q    <= crow_q;
            out_col_q    <= ccol_q;
            out_region_q <= region_q;
            out_corner_q <= corner;
            out_resp_q   <= corner ? quo_q : '0;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/structure_tensor_corner_response.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// structure_tensor_corner_response: streaming corner detector
// Takes raster gradient pairs, sums the structure tensor over a square window
// and reports per window center whether it is a corner and, for a corner, its det/trace^2.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake               | beat
//  --------+-----------+-------------------------+-------------------------------
//  cfg     | in        | cfg_we_i                | cfg_idx_i, cfg_data_i
//  in      | in        | in_valid_i / in_stall_o | grad_x_i, grad_y_i
//  out     | out       | out_valid_o/out_stall_i | center_row_o .. response_o
//
//  Intake: an input beat holds the intake through 2r+1 line reads and, once a
//  center exists, the 21-step center divider, and waits for room in the queue.
//  Response path: 2r+1 window adds, 6 split-multiplier passes and 15 divide
//  steps per in-region beat; any other beat goes straight to the output register.
//  Reset: the line store is cleared, one column per cycle over all its columns,
//  in_stall_o high meanwhile. Stalls: a two-beat queue and the output register.
// ----------------------------------------------------------------------------
module structure_tensor_corner_response (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [stc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [stc_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [stc_pkg::GRAD_W-1:0]   grad_x_i,
  input  logic signed [stc_pkg::GRAD_W-1:0]   grad_y_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [stc_pkg::ROW_W-1:0]           center_row_o,
  output logic [stc_pkg::COL_W-1:0]           center_col_o,
  output logic                                in_region_o,
  output logic                                is_corner_o,
  output logic [stc_pkg::RESP_W-1:0]          response_o
);

  logic [stc_pkg::DIM_W-1:0]  width_q;
  logic [stc_pkg::DIM_W-1:0]  height_q;
  logic [stc_pkg::RAD_W-1:0]  radius_q;
  logic [stc_pkg::DTHR_W-1:0] det_thr_q;
  logic [stc_pkg::RTHR_W-1:0] ratio_thr_q;

  stc_pkg::cfg_t      cfg;
  stc_pkg::col_item_t push_data;
  stc_pkg::col_item_t pop_data;
  logic               q_push;
  logic               q_full;
  logic               q_pop;
  logic               q_valid;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= stc_pkg::DIM_W'(stc_pkg::RST_WIDTH);
      height_q    <= stc_pkg::DIM_W'(stc_pkg::RST_HEIGHT);
      radius_q    <= stc_pkg::RAD_W'(stc_pkg::RST_RADIUS);
      det_thr_q   <= stc_pkg::DTHR_W'(stc_pkg::RST_DET_THR);
      ratio_thr_q <= stc_pkg::RTHR_W'(stc_pkg::RST_RATIO_THR);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        stc_pkg::REG_WIDTH:     width_q     <= cfg_data_i[stc_pkg::DIM_W-1:0];
        stc_pkg::REG_HEIGHT:    height_q    <= cfg_data_i[stc_pkg::DIM_W-1:0];
        stc_pkg::REG_RADIUS:    radius_q    <= cfg_data_i[stc_pkg::RAD_W-1:0];
        stc_pkg::REG_DET_THR:   det_thr_q   <= cfg_data_i[stc_pkg::DTHR_W-1:0];
        stc_pkg::REG_RATIO_THR: ratio_thr_q <= cfg_data_i[stc_pkg::RTHR_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp dimensions and radius to their working range
  always_comb begin
    cfg = '0;
    if (width_q == '0) begin
      cfg.width = stc_pkg::DIM_W'(1);
    end else if (width_q > stc_pkg::DIM_W'(stc_pkg::MAX_WIDTH)) begin
      cfg.width = stc_pkg::DIM_W'(stc_pkg::MAX_WIDTH);
    end else begin
      cfg.width = width_q;
    end
    if (height_q == '0) begin
      cfg.height = stc_pkg::DIM_W'(1);
    end else if (height_q > stc_pkg::DIM_W'(stc_pkg::MAX_HEIGHT)) begin
      cfg.height = stc_pkg::DIM_W'(stc_pkg::MAX_HEIGHT);
    end else begin
      cfg.height = height_q;
    end
    cfg.radius    = (radius_q == '0) ? stc_pkg::RAD_W'(1) : radius_q;
    cfg.det_thr   = det_thr_q;
    cfg.ratio_thr = ratio_thr_q;
  end

  stc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .grad_x_i    (grad_x_i),
    .grad_y_i    (grad_y_i),
    .push_o      (q_push),
    .push_data_o (push_data),
    .full_i      (q_full)
  );

  stc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_data)
  );

  stc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .pop_valid_i  (q_valid),
    .pop_data_i   (pop_data),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .center_row_o (center_row_o),
    .center_col_o (center_col_o),
    .in_region_o  (in_region_o),
    .is_corner_o  (is_corner_o),
    .response_o   (response_o)
  );

`ifndef SYNTHESIS
  a_resp_needs_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_corner_o |-> response_o == '0)
    else $error("response without corner flag");

  a_corner_in_region: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_corner_o |-> in_region_o)
    else $error("corner outside region");

  a_resp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> response_o <= stc_pkg::RESP_W'(stc_pkg::RESP_MAX))
    else $error("response above one quarter");

  a_queue_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("push into full queue");
`endif

endmodule
